// ----- rtl/multibulk_request_parser_defines.svh -----
// assertion macros used by the multi-bulk request parser checker
`ifndef MULTIBULK_REQUEST_PARSER_DEFINES_SVH
`define MULTIBULK_REQUEST_PARSER_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define MBRP_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define MBRP_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/mbrp_pkg.sv -----
// types, byte codes and constants of the multi-bulk request parser
package mbrp_pkg;

    // protocol bytes
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    // length limits
    localparam int unsigned LEN_W         = 12;
    localparam int unsigned SUM_W         = 13;
    localparam logic [SUM_W-1:0] LEN_SAT  = 13'd4096;
    localparam logic [LEN_W-1:0] MAX_LEN_RESET = 12'd1024;

    typedef enum logic [3:0] {
        PH_MSG_MARK  = 4'd0,
        PH_CNT_DIGIT = 4'd1,
        PH_CNT_CR    = 4'd2,
        PH_CNT_LF    = 4'd3,
        PH_SL_MARK   = 4'd4,
        PH_LEN_FIRST = 4'd5,
        PH_LEN_MORE  = 4'd6,
        PH_LEN_LF    = 4'd7,
        PH_PAYLOAD   = 4'd8,
        PH_TRAIL1    = 4'd9,
        PH_TRAIL2    = 4'd10,
        PH_RESYNC    = 4'd11
    } phase_t;

    typedef enum logic [1:0] {
        K_DATA  = 2'd0,
        K_SLICE = 2'd1,
        K_MSG   = 2'd2,
        K_ERR   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        E_MARKER    = 2'd0,
        E_DIGIT     = 2'd1,
        E_LINE      = 2'd2,
        E_TOO_LARGE = 2'd3
    } err_t;

    typedef struct packed {
        phase_t           phase;
        logic [3:0]       slice_count;
        logic [3:0]       slice_number;
        logic [SUM_W-1:0] length_sum;
        logic [LEN_W-1:0] bytes_left;
    } parse_state_t;

    typedef struct packed {
        kind_t            kind;
        logic [7:0]       data_byte;
        logic [3:0]       slice_index;
        logic [LEN_W-1:0] slice_length;
        err_t             error_code;
    } result_t;

endpackage

// ----- rtl/mbrp_step.sv -----
// one parse step: next parser state and the optional result for one byte
module mbrp_step (
    input  mbrp_pkg::parse_state_t st,
    input  logic [7:0]             in_byte,
    input  logic [11:0]            max_len,
    output mbrp_pkg::parse_state_t st_next,
    output logic                   has_res,
    output mbrp_pkg::result_t      res
);
    import mbrp_pkg::*;

    logic             is_digit;
    logic [3:0]       digit;
    logic [15:0]      acc;
    logic [SUM_W-1:0] sum_acc;
    logic [LEN_W-1:0] len_clip;
    logic [3:0]       sn_inc;
    logic             fail;
    err_t             fail_code;

    // digit decode and saturating length accumulation
    always_comb
    begin
        is_digit = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
        digit    = in_byte[3:0];
        acc      = {st.length_sum, 3'b000} + {2'b00, st.length_sum, 1'b0} + {12'd0, digit};
        sum_acc  = (acc > {3'd0, LEN_SAT}) ? LEN_SAT : acc[SUM_W-1:0];
        len_clip = st.length_sum[SUM_W-1] ? {LEN_W{1'b1}} : st.length_sum[LEN_W-1:0];
        sn_inc   = st.slice_number + 4'd1;
    end

    // next state and result per phase
    always_comb
    begin
        st_next   = st;
        has_res   = 1'b0;
        fail      = 1'b0;
        fail_code = E_MARKER;
        res.kind         = K_DATA;
        res.data_byte    = 8'd0;
        res.slice_index  = st.slice_number;
        res.slice_length = len_clip;
        res.error_code   = E_MARKER;

        unique case (st.phase)
            PH_MSG_MARK:
            begin
                if (in_byte != CH_STAR)
                begin
                    fail      = 1'b1;
                    fail_code = E_MARKER;
                end
                else
                begin
                    st_next = '{PH_CNT_DIGIT, 4'd0, 4'd0, '0, '0};
                end
            end
            PH_CNT_DIGIT:
            begin
                if (!is_digit)
                begin
                    fail      = 1'b1;
                    fail_code = E_DIGIT;
                end
                else
                begin
                    st_next.slice_count = digit;
                    st_next.phase       = PH_CNT_CR;
                end
            end
            PH_CNT_CR:
            begin
                if (in_byte != CH_CR)
                begin
                    fail      = 1'b1;
                    fail_code = E_LINE;
                end
                else
                begin
                    st_next.phase = PH_CNT_LF;
                end
            end
            PH_CNT_LF:
            begin
                if (in_byte != CH_LF)
                begin
                    fail      = 1'b1;
                    fail_code = E_LINE;
                end
                else
                begin
                    st_next.slice_number = 4'd0;
                    st_next.phase = (st.slice_count == 4'd0) ? PH_MSG_MARK : PH_SL_MARK;
                end
            end
            PH_SL_MARK:
            begin
                if (in_byte != CH_DOLLAR)
                begin
                    fail      = 1'b1;
                    fail_code = E_MARKER;
                end
                else
                begin
                    st_next.length_sum = '0;
                    st_next.phase      = PH_LEN_FIRST;
                end
            end
            PH_LEN_FIRST:
            begin
                if (!is_digit)
                begin
                    fail      = 1'b1;
                    fail_code = E_DIGIT;
                end
                else
                begin
                    st_next.length_sum = sum_acc;
                    st_next.phase      = PH_LEN_MORE;
                end
            end
            PH_LEN_MORE:
            begin
                if (is_digit)
                begin
                    st_next.length_sum = sum_acc;
                end
                else if (in_byte != CH_CR)
                begin
                    fail      = 1'b1;
                    fail_code = E_LINE;
                end
                else
                begin
                    st_next.phase = PH_LEN_LF;
                end
            end
            PH_LEN_LF:
            begin
                if (in_byte != CH_LF)
                begin
                    fail      = 1'b1;
                    fail_code = E_LINE;
                end
                else if (st.length_sum > {1'b0, max_len})
                begin
                    fail      = 1'b1;
                    fail_code = E_TOO_LARGE;
                end
                else
                begin
                    st_next.bytes_left = st.length_sum[LEN_W-1:0];
                    st_next.phase = (st.length_sum == '0) ? PH_TRAIL1 : PH_PAYLOAD;
                end
            end
            PH_PAYLOAD:
            begin
                has_res            = 1'b1;
                res.kind           = K_DATA;
                res.data_byte      = in_byte;
                st_next.bytes_left = st.bytes_left - 12'd1;
                if (st.bytes_left == 12'd1)
                begin
                    st_next.phase = PH_TRAIL1;
                end
            end
            PH_TRAIL1:
            begin
                st_next.phase = PH_TRAIL2;
            end
            PH_TRAIL2:
            begin
                has_res = 1'b1;
                if (sn_inc >= st.slice_count)
                begin
                    res.kind             = K_MSG;
                    st_next.phase        = PH_MSG_MARK;
                    st_next.slice_count  = 4'd0;
                    st_next.slice_number = 4'd0;
                    st_next.length_sum   = '0;
                end
                else
                begin
                    res.kind             = K_SLICE;
                    st_next.slice_number = sn_inc;
                    st_next.length_sum   = '0;
                    st_next.phase        = PH_SL_MARK;
                end
            end
            PH_RESYNC:
            begin
                if (in_byte == CH_STAR)
                begin
                    st_next = '{PH_CNT_DIGIT, 4'd0, 4'd0, '0, '0};
                end
            end
            default:
            begin
                st_next.phase = PH_RESYNC;
            end
        endcase

        // error result, state cleared and waiting for a new message marker
        if (fail)
        begin
            has_res        = 1'b1;
            res.kind       = K_ERR;
            res.data_byte  = 8'd0;
            res.error_code = fail_code;
            st_next        = '{PH_RESYNC, 4'd0, 4'd0, '0, '0};
        end
    end

endmodule

// ----- rtl/multibulk_request_parser.sv -----
// multi-bulk request parser: one byte in per cycle unless stalled, payload and event items out
// a byte is held in the input register and its result item in the output register
// throughput: one byte per cycle unless stalled; resultless bytes still use the input register
// the held byte moves on if it has no result or the output register is empty or being taken
// reset clears the parser to expect a message marker and max_slice_length to 1024
module multibulk_request_parser (
    input  logic        clk,
    input  logic        rst_n,
    // configuration: max_slice_length
    input  logic        cfg_we,
    input  logic [11:0] cfg_wdata,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [7:0] data_byte, [11:8] slice_index,
                                        // [23:12] slice_length, [25:24] error_code
    output logic [1:0]  m_axis_tuser    // [1:0] kind
);
    import mbrp_pkg::*;

    logic         in_vld_reg;
    logic         in_vld_next;
    logic [7:0]   in_byte_reg;
    logic [11:0]  max_len_reg;
    parse_state_t state_reg;
    parse_state_t state_next;
    logic         out_vld_reg;
    logic         out_vld_next;
    result_t      out_res_reg;
    logic         has_res;
    result_t      res;
    logic         adv;
    logic         in_acc;

    // parse step between input and result registers
    mbrp_step u_step (
        .st      (state_reg),
        .in_byte (in_byte_reg),
        .max_len (max_len_reg),
        .st_next (state_next),
        .has_res (has_res),
        .res     (res)
    );

    // handshake: the held byte moves on when it has no result or its result has room
    always_comb
    begin
        adv           = in_vld_reg && (!has_res || !out_vld_reg || m_axis_tready);
        s_axis_tready = !in_vld_reg || adv;
        in_acc        = s_axis_tvalid && s_axis_tready;
        in_vld_next   = in_acc ? 1'b1 : (adv ? 1'b0 : in_vld_reg);
        if (adv && has_res)
        begin
            out_vld_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_vld_next = 1'b0;
        end
        else
        begin
            out_vld_next = out_vld_reg;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            max_len_reg <= MAX_LEN_RESET;
            state_reg   <= '{PH_MSG_MARK, 4'd0, 4'd0, '0, '0};
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
            if (cfg_we)
            begin
                max_len_reg <= cfg_wdata;
            end
            if (adv)
            begin
                state_reg <= state_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            in_byte_reg <= s_axis_tdata;
        end
        if (adv && has_res)
        begin
            out_res_reg <= res;
        end
    end

    // result channel
    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tuser  = out_res_reg.kind;
    assign m_axis_tdata  = {6'd0, out_res_reg.error_code, out_res_reg.slice_length,
                            out_res_reg.slice_index, out_res_reg.data_byte};

endmodule

// ----- rtl/mbrp_checker.sv -----
// port-level checker for the multi-bulk request parser and its bind
`include "multibulk_request_parser_defines.svh"

module mbrp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);
    import mbrp_pkg::*;

    // a stalled result holds
    `MBRP_ASSERT_NXT(a_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

    // error code is zero outside error items
    `MBRP_ASSERT_IMP(a_code, clk, rst_n, m_axis_tvalid && (m_axis_tuser != K_ERR), m_axis_tdata[25:24] == 2'd0, "error code set on non-error item")

    // data byte is zero outside payload items
    `MBRP_ASSERT_IMP(a_data, clk, rst_n, m_axis_tvalid && (m_axis_tuser != K_DATA), m_axis_tdata[7:0] == 8'd0, "data byte set on non-payload item")

    // payload only comes from a slice of nonzero length
    `MBRP_ASSERT_IMP(a_len, clk, rst_n, m_axis_tvalid && (m_axis_tuser == K_DATA), m_axis_tdata[23:12] != 12'd0, "payload item with zero slice length")

    // at most nine slices per message
    `MBRP_ASSERT_IMP(a_idx, clk, rst_n, m_axis_tvalid, m_axis_tdata[11:8] <= 4'd8, "slice index out of range")

endmodule

bind multibulk_request_parser mbrp_checker u_mbrp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
